FILE: rtl/amq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amq_pkg;

	// Default widths of the sensor words and of the output fraction.
	localparam int IN_WIDTH_DEF = 32;
	localparam int OUT_FRAC_DEF = 30;

	// Output word width and the unit value of the internal Q30 format.
	localparam int QW = 32;
	localparam int UNIT_ONE = 1 << 30;

	// One finished result as it waits in the output buffer.
	typedef struct packed {
		logic [QW-1:0] quat_w;
		logic [QW-1:0] quat_x;
		logic [QW-1:0] quat_y;
		logic [QW-1:0] quat_z;
		logic          valid_res;
	} amq_res_t;

endpackage

`default_nettype wire

FILE: rtl/amq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface amq_in_if #(
	parameter int IN_WIDTH = amq_pkg::IN_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic [IN_WIDTH-1:0] accel_x;
	logic [IN_WIDTH-1:0] accel_y;
	logic [IN_WIDTH-1:0] accel_z;
	logic [IN_WIDTH-1:0] mag_x;
	logic [IN_WIDTH-1:0] mag_y;
	logic [IN_WIDTH-1:0] mag_z;

	modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/amq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface amq_out_if;
	logic                    valid;
	logic                    ready;
	logic [amq_pkg::QW-1:0]  quat_w;
	logic [amq_pkg::QW-1:0]  quat_x;
	logic [amq_pkg::QW-1:0]  quat_y;
	logic [amq_pkg::QW-1:0]  quat_z;
	logic                    valid_res;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, valid_res, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, valid_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/amq_norm.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined vector normalizer. Output components are signed Q30 unit values.
// The square root and the dividers resolve one result bit per stage.
module amq_norm #(
	parameter int N   = 3,
	parameter int IW  = 32,
	parameter int FSH = 0,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  logic [IW-1:0]  a_in [N],
	input  logic [SBW-1:0] sb_in,
	output logic           v_out,
	output logic           ok_out,
	output logic [31:0]    u_out [N],
	output logic [SBW-1:0] sb_out
);
	import amq_pkg::*;

	localparam int MW  = (IW > 24) ? IW : 24;
	localparam int PW  = $clog2(MW + 1);
	localparam int SQS = 32;
	localparam int DVS = 31;

	// Stage 1: magnitudes and signs.
	logic [IW-1:0]  abs_c  [N];
	logic           v_s1;
	logic [MW-1:0]  mag_s1 [N];
	logic [N-1:0]   neg_s1;
	logic [SBW-1:0] sb_s1;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			abs_c[i] = a_in[i][IW-1] ? (~a_in[i] + IW'(1)) : a_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				mag_s1[i] <= MW'(abs_c[i]);
				neg_s1[i] <= a_in[i][IW-1];
			end
			sb_s1 <= sb_in;
		end
	end

	// Stage 2: leading one of the largest magnitude and the degenerate test.
	logic [MW-1:0]  orv_c;
	logic [PW-1:0]  pos_c;
	logic           v_s2, ok_s2;
	logic [PW-1:0]  pos_s2;
	logic [MW-1:0]  mag_s2 [N];
	logic [N-1:0]   neg_s2;
	logic [SBW-1:0] sb_s2;

	always_comb begin
		orv_c = '0;
		for (int i = 0; i < N; i++) begin
			orv_c = orv_c | mag_s1[i];
		end
		pos_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (orv_c[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2  <= ((orv_c >> FSH) != '0);
			pos_s2 <= pos_c;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;
		end
	end

	// Stage 3: shift all components so the largest lies in [2^23, 2^24).
	logic [23:0]    m24_c  [N];
	logic           v_s3, ok_s3;
	logic [23:0]    m24_s3 [N];
	logic [N-1:0]   neg_s3;
	logic [SBW-1:0] sb_s3;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (pos_s2 >= PW'(23)) begin
				m24_c[i] = 24'(mag_s2[i] >> (pos_s2 - PW'(23)));
			end else begin
				m24_c[i] = 24'(mag_s2[i] << (PW'(23) - pos_s2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3  <= ok_s2;
			m24_s3 <= m24_c;
			neg_s3 <= neg_s2;
			sb_s3  <= sb_s2;
		end
	end

	// Stage 4: squares.
	logic [47:0]    sq_c   [N];
	logic           v_s4, ok_s4;
	logic [47:0]    sq_s4  [N];
	logic [23:0]    m24_s4 [N];
	logic [N-1:0]   neg_s4;
	logic [SBW-1:0] sb_s4;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			sq_c[i] = m24_s3[i] * m24_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= ok_s3;
			sq_s4  <= sq_c;
			m24_s4 <= m24_s3;
			neg_s4 <= neg_s3;
			sb_s4  <= sb_s3;
		end
	end

	// Stage 5 and the square root stages: index 0 holds the scaled sum.
	logic [63:0]    sum_c;
	logic [63:0]    qx_s  [SQS+1];
	logic [63:0]    qr_s  [SQS+1];
	logic [23:0]    qm_s  [SQS+1][N];
	logic [N-1:0]   qn_s  [SQS+1];
	logic           qok_s [SQS+1];
	logic [SBW-1:0] qsb_s [SQS+1];
	logic           qv_s  [SQS+1];
	logic [63:0]    qx_n  [SQS];
	logic [63:0]    qr_n  [SQS];

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < N; i++) begin
			sum_c = sum_c + 64'(sq_s4[i]);
		end
	end

	// One result bit of the integer square root per stage.
	always_comb begin
		logic [63:0] bitv;
		logic [63:0] trial;
		for (int k = 0; k < SQS; k++) begin
			bitv  = 64'(1) << (62 - 2 * k);
			trial = qr_s[k] + bitv;
			if (qx_s[k] >= trial) begin
				qx_n[k] = qx_s[k] - trial;
				qr_n[k] = (qr_s[k] >> 1) + bitv;
			end else begin
				qx_n[k] = qx_s[k];
				qr_n[k] = qr_s[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s[0]  <= sum_c << 12;
			qr_s[0]  <= '0;
			qm_s[0]  <= m24_s4;
			qn_s[0]  <= neg_s4;
			qok_s[0] <= ok_s4;
			qsb_s[0] <= sb_s4;
			for (int k = 0; k < SQS; k++) begin
				qx_s[k+1]  <= qx_n[k];
				qr_s[k+1]  <= qr_n[k];
				qm_s[k+1]  <= qm_s[k];
				qn_s[k+1]  <= qn_s[k];
				qok_s[k+1] <= qok_s[k];
				qsb_s[k+1] <= qsb_s[k];
			end
		end
	end

	// Divider stages: index 0 holds the rounded numerators.
	logic [30:0]    dr_s  [DVS+1];
	logic [61:0]    dm_s  [DVS+1][N];
	logic [30:0]    dq_s  [DVS+1][N];
	logic [N-1:0]   dn_s  [DVS+1];
	logic           dok_s [DVS+1];
	logic [SBW-1:0] dsb_s [DVS+1];
	logic           dv_s  [DVS+1];
	logic [61:0]    dm_n  [DVS][N];
	logic [30:0]    dq_n  [DVS][N];
	logic [30:0]    root_c;

	assign root_c = qr_s[SQS][30:0];

	// One quotient bit per stage for each component.
	always_comb begin
		logic [61:0] cmp;
		for (int j = 0; j < DVS; j++) begin
			cmp = 62'(dr_s[j]) << (DVS - 1 - j);
			for (int i = 0; i < N; i++) begin
				if (dm_s[j][i] >= cmp) begin
					dm_n[j][i] = dm_s[j][i] - cmp;
					dq_n[j][i] = dq_s[j][i] | (31'(1) << (DVS - 1 - j));
				end else begin
					dm_n[j][i] = dm_s[j][i];
					dq_n[j][i] = dq_s[j][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s[0]  <= root_c;
			for (int i = 0; i < N; i++) begin
				dm_s[0][i] <= (62'(qm_s[SQS][i]) << 36) + 62'(root_c >> 1);
				dq_s[0][i] <= '0;
			end
			dn_s[0]  <= qn_s[SQS];
			dok_s[0] <= qok_s[SQS];
			dsb_s[0] <= qsb_s[SQS];
			for (int j = 0; j < DVS; j++) begin
				dr_s[j+1]  <= dr_s[j];
				dm_s[j+1]  <= dm_n[j];
				dq_s[j+1]  <= dq_n[j];
				dn_s[j+1]  <= dn_s[j];
				dok_s[j+1] <= dok_s[j];
				dsb_s[j+1] <= dsb_s[j];
			end
		end
	end

	// Final stage: clamp to one and restore the sign.
	logic [31:0] u_c [N];

	always_comb begin
		logic [30:0] qc;
		for (int i = 0; i < N; i++) begin
			qc = dq_s[DVS][i];
			if (qc > 31'(UNIT_ONE)) begin
				qc = 31'(UNIT_ONE);
			end
			u_c[i] = dn_s[DVS][i] ? (~{1'b0, qc} + 32'd1) : {1'b0, qc};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_out  <= u_c;
			ok_out <= dok_s[DVS];
			sb_out <= dsb_s[DVS];
		end
	end

	// Valid bits travel with the data and are the only reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_out <= 1'b0;
			for (int k = 0; k <= SQS; k++) begin
				qv_s[k] <= 1'b0;
			end
			for (int j = 0; j <= DVS; j++) begin
				dv_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= v_in;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			qv_s[0] <= v_s4;
			for (int k = 0; k < SQS; k++) begin
				qv_s[k+1] <= qv_s[k];
			end
			dv_s[0] <= qv_s[SQS];
			for (int j = 0; j < DVS; j++) begin
				dv_s[j+1] <= dv_s[j];
			end
			v_out <= dv_s[DVS];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/accel_mag_to_quaternion_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                   | Format
// sens    | in  | accel_x/y/z, mag_x/y/z                    | signed, IN_WIDTH bits
// quat    | out | quat_w/x/y/z, valid_res                   | signed Q2.30 (OUT_FRAC_BITS)
//
// One transfer is taken every cycle while the output buffer is not full; results come out in order.
// The path runs through four passes of the 70-stage normalizer, whose square root
// and dividers resolve one bit per stage, plus six cross-product and output stages.
// Reset clears only the valid bits and the output buffer count and pointers.
// A two-entry output buffer keeps taking transfers while one result waits; the pipeline
// holds only when both entries are full.
module accel_mag_to_quaternion_core #(
	parameter int IN_WIDTH      = amq_pkg::IN_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = amq_pkg::OUT_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	amq_in_if.sink     sens,
	amq_out_if.source  quat
);
	import amq_pkg::*;

	localparam int UP_SH = (OUT_FRAC_BITS >= 30) ? (OUT_FRAC_BITS - 30) : 0;
	localparam int DN_SH = (OUT_FRAC_BITS < 30) ? (30 - OUT_FRAC_BITS) : 1;

	// Q30 to the output format with rounding and saturation.
	function automatic logic [31:0] to_out(input logic [31:0] q30);
		logic        neg;
		logic [31:0] m;
		logic [63:0] mm;
		logic [63:0] lim;
		neg = q30[31];
		m   = neg ? (~q30 + 32'd1) : q30;
		if (OUT_FRAC_BITS >= 30) begin
			mm = 64'(m) << UP_SH;
		end else begin
			mm = (64'(m) + (64'(1) << (DN_SH - 1))) >> DN_SH;
		end
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (mm > lim) begin
			mm = lim;
		end
		return neg ? (~mm[31:0] + 32'd1) : mm[31:0];
	endfunction

	// Pipeline advance: held only while the output buffer is full.
	logic [1:0] cnt_q;
	logic       en;

	assign en         = (cnt_q != 2'd2);
	assign sens.ready = en;

	// Normalize the accelerometer (up) and magnetometer vectors.
	logic [IN_WIDTH-1:0] acc_c [3];
	logic [IN_WIDTH-1:0] mgi_c [3];
	logic                va, vm, oka, okm;
	logic [0:0]          sba, sbm;
	logic [31:0]         ua [3];
	logic [31:0]         um [3];

	assign acc_c[0] = sens.accel_x;
	assign acc_c[1] = sens.accel_y;
	assign acc_c[2] = sens.accel_z;
	assign mgi_c[0] = sens.mag_x;
	assign mgi_c[1] = sens.mag_y;
	assign mgi_c[2] = sens.mag_z;

	amq_norm #(.N(3), .IW(IN_WIDTH), .FSH(0), .SBW(1)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(sens.valid), .a_in(acc_c),
		.sb_in(1'b1), .v_out(va), .ok_out(oka), .u_out(ua), .sb_out(sba)
	);

	amq_norm #(.N(3), .IW(IN_WIDTH), .FSH(0), .SBW(1)) u_norm_mag (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(sens.valid), .a_in(mgi_c),
		.sb_in(1'b1), .v_out(vm), .ok_out(okm), .u_out(um), .sb_out(sbm)
	);

	// East = up x magnetic: products, then differences.
	logic signed [63:0] pe_c [6];
	logic signed [63:0] pe_s1 [6];
	logic [31:0]        up_s1 [3];
	logic               v_s1, ok_s1;
	logic [63:0]        ec_s2 [3];
	logic [31:0]        up_s2 [3];
	logic               v_s2, ok_s2;

	assign pe_c[0] = $signed(ua[1]) * $signed(um[2]);
	assign pe_c[1] = $signed(ua[2]) * $signed(um[1]);
	assign pe_c[2] = $signed(ua[2]) * $signed(um[0]);
	assign pe_c[3] = $signed(ua[0]) * $signed(um[2]);
	assign pe_c[4] = $signed(ua[0]) * $signed(um[1]);
	assign pe_c[5] = $signed(ua[1]) * $signed(um[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s1 <= pe_c;
			up_s1 <= ua;
			ok_s1 <= oka & okm & sba[0] & sbm[0];
			for (int i = 0; i < 3; i++) begin
				ec_s2[i] <= pe_s1[2*i] - pe_s1[2*i+1];
			end
			up_s2 <= up_s1;
			ok_s2 <= ok_s1;
		end
	end

	// Normalize east; up rides along in the sideband.
	logic         ve, oke;
	logic [31:0]  ue [3];
	logic [96:0]  sbe_in, sbe;

	assign sbe_in = {ok_s2, up_s2[0], up_s2[1], up_s2[2]};

	amq_norm #(.N(3), .IW(64), .FSH(30), .SBW(97)) u_norm_east (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s2), .a_in(ec_s2),
		.sb_in(sbe_in), .v_out(ve), .ok_out(oke), .u_out(ue), .sb_out(sbe)
	);

	// North = east x up: products, then differences.
	logic [31:0]        upe [3];
	logic signed [63:0] pn_c [6];
	logic signed [63:0] pn_s3 [6];
	logic [31:0]        up_s3 [3];
	logic [31:0]        ea_s3 [3];
	logic               v_s3, ok_s3;
	logic [63:0]        nc_s4 [3];
	logic [31:0]        up_s4 [3];
	logic [31:0]        ea_s4 [3];
	logic               v_s4, ok_s4;

	assign upe[0] = sbe[95:64];
	assign upe[1] = sbe[63:32];
	assign upe[2] = sbe[31:0];

	assign pn_c[0] = $signed(ue[1]) * $signed(upe[2]);
	assign pn_c[1] = $signed(ue[2]) * $signed(upe[1]);
	assign pn_c[2] = $signed(ue[2]) * $signed(upe[0]);
	assign pn_c[3] = $signed(ue[0]) * $signed(upe[2]);
	assign pn_c[4] = $signed(ue[0]) * $signed(upe[1]);
	assign pn_c[5] = $signed(ue[1]) * $signed(upe[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pn_s3 <= pn_c;
			up_s3 <= upe;
			ea_s3 <= ue;
			ok_s3 <= oke & sbe[96];
			for (int i = 0; i < 3; i++) begin
				nc_s4[i] <= pn_s3[2*i] - pn_s3[2*i+1];
			end
			up_s4 <= up_s3;
			ea_s4 <= ea_s3;
			ok_s4 <= ok_s3;
		end
	end

	// Normalize north; up and east ride along.
	logic         vn, okn;
	logic [31:0]  un [3];
	logic [192:0] sbn_in, sbn;

	assign sbn_in = {ok_s4, up_s4[0], up_s4[1], up_s4[2], ea_s4[0], ea_s4[1], ea_s4[2]};

	amq_norm #(.N(3), .IW(64), .FSH(30), .SBW(193)) u_norm_north (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s4), .a_in(nc_s4),
		.sb_in(sbn_in), .v_out(vn), .ok_out(okn), .u_out(un), .sb_out(sbn)
	);

	// Trace method on the matrix with columns north, east and up.
	logic signed [33:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, tr, d_c;
	logic signed [33:0] qv_c [4];
	logic [33:0]        qv_s5 [4];
	logic               v_s5, ok_s5;

	assign r00 = {{2{un[0][31]}}, un[0]};
	assign r10 = {{2{un[1][31]}}, un[1]};
	assign r20 = {{2{un[2][31]}}, un[2]};
	assign r01 = {{2{sbn[95]}}, sbn[95:64]};
	assign r11 = {{2{sbn[63]}}, sbn[63:32]};
	assign r21 = {{2{sbn[31]}}, sbn[31:0]};
	assign r02 = {{2{sbn[191]}}, sbn[191:160]};
	assign r12 = {{2{sbn[159]}}, sbn[159:128]};
	assign r22 = {{2{sbn[127]}}, sbn[127:96]};
	assign tr  = r00 + r11 + r22;

	always_comb begin
		priority if (tr > 34'sd0) begin
			d_c     = 34'(UNIT_ONE) + tr;
			qv_c[0] = d_c;
			qv_c[1] = r21 - r12;
			qv_c[2] = r02 - r20;
			qv_c[3] = r10 - r01;
		end else if (r00 > r11 && r00 > r22) begin
			d_c     = 34'(UNIT_ONE) + r00 - r11 - r22;
			qv_c[0] = r21 - r12;
			qv_c[1] = d_c;
			qv_c[2] = r01 + r10;
			qv_c[3] = r02 + r20;
		end else if (r11 > r22) begin
			d_c     = 34'(UNIT_ONE) + r11 - r00 - r22;
			qv_c[0] = r02 - r20;
			qv_c[1] = r01 + r10;
			qv_c[2] = d_c;
			qv_c[3] = r12 + r21;
		end else begin
			d_c     = 34'(UNIT_ONE) + r22 - r00 - r11;
			qv_c[0] = r10 - r01;
			qv_c[1] = r02 + r20;
			qv_c[2] = r12 + r21;
			qv_c[3] = d_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				qv_s5[i] <= qv_c[i];
			end
			ok_s5 <= okn & sbn[192] & (d_c > 34'sd0);
		end
	end

	// Normalize the unscaled quaternion.
	logic        vq, okq;
	logic [31:0] uq [4];
	logic [0:0]  sbq;

	amq_norm #(.N(4), .IW(34), .FSH(0), .SBW(1)) u_norm_quat (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s5), .a_in(qv_s5),
		.sb_in(ok_s5), .v_out(vq), .ok_out(okq), .u_out(uq), .sb_out(sbq)
	);

	// Output format conversion, identity on a degenerate input.
	amq_res_t res_s6, res_c;
	logic     v_s6;

	always_comb begin
		if (okq & sbq[0]) begin
			res_c.quat_w    = to_out(uq[0]);
			res_c.quat_x    = to_out(uq[1]);
			res_c.quat_y    = to_out(uq[2]);
			res_c.quat_z    = to_out(uq[3]);
			res_c.valid_res = 1'b1;
		end else begin
			res_c.quat_w    = to_out(32'(UNIT_ONE));
			res_c.quat_x    = '0;
			res_c.quat_y    = '0;
			res_c.quat_z    = '0;
			res_c.valid_res = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_c;
		end
	end

	// Valid bits of the stages outside the normalizers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= va & vm;
			v_s2 <= v_s1;
			v_s3 <= ve;
			v_s4 <= v_s3;
			v_s5 <= vn;
			v_s6 <= vq;
		end
	end

	// Two-entry output buffer.
	amq_res_t buf_q [2];
	logic     wr_q, rd_q;
	logic     push, pop;

	assign push = en & v_s6;
	assign pop  = quat.valid & quat.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	assign quat.valid     = (cnt_q != 2'd0);
	assign quat.quat_w    = buf_q[rd_q].quat_w;
	assign quat.quat_x    = buf_q[rd_q].quat_x;
	assign quat.quat_y    = buf_q[rd_q].quat_y;
	assign quat.quat_z    = buf_q[rd_q].quat_z;
	assign quat.valid_res = buf_q[rd_q].valid_res;

endmodule

`default_nettype wire

FILE: rtl/amq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module amq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] quat_w,
	input logic [31:0] quat_x,
	input logic [31:0] quat_y,
	input logic [31:0] quat_z,
	input logic        valid_res
);
	// Count of transfers taken in whose results are not yet delivered.
	logic [9:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {9'd0, in_valid & in_ready} - {9'd0, out_valid & out_ready};
		end
	end

	// A result is never delivered without an earlier input transfer.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> pend_q != 10'd0)
		else $error("result delivered with no pending input");

	// A degenerate result carries the identity quaternion.
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> quat_x == 32'd0 && quat_y == 32'd0 &&
		quat_z == 32'd0 && quat_w != 32'd0)
		else $error("degenerate result is not the identity");

	// A computed quaternion is never all zero.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> !(quat_w == 32'd0 && quat_x == 32'd0 &&
		quat_y == 32'd0 && quat_z == 32'd0))
		else $error("computed quaternion is zero");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x) &&
		$stable(quat_y) && $stable(quat_z) && $stable(valid_res))
		else $error("stalled result changed");

endmodule

bind accel_mag_to_quaternion_core amq_checker u_amq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sens.valid),
	.in_ready(sens.ready),
	.out_valid(quat.valid),
	.out_ready(quat.ready),
	.quat_w(quat.quat_w),
	.quat_x(quat.quat_x),
	.quat_y(quat.quat_y),
	.quat_z(quat.quat_z),
	.valid_res(quat.valid_res)
);

`default_nettype wire
